>>> rtl/bpwm_pkg.sv
// Package for the byte port word memory: shared constants, strobe count codes
// and the RAM control struct. No dependencies.
`default_nettype none

package bpwm_pkg;

   localparam int ADDR_BITS_DEF = 13;   // default store depth is 2**13 words
   localparam int WORD_W        = 32;
   localparam int BYTE_W        = 8;
   localparam int WADDR_W       = 19;   // host word address width
   localparam int CNT_W         = 3;

   localparam logic [2:0] HI_ADDR_MASK = 3'h7;

   // strobe position within one access
   localparam logic [CNT_W-1:0] CNT_ADDR_HI  = 3'd0;
   localparam logic [CNT_W-1:0] CNT_ADDR_MID = 3'd1;
   localparam logic [CNT_W-1:0] CNT_ADDR_LO  = 3'd2;
   localparam logic [CNT_W-1:0] CNT_DATA_0   = 3'd3;
   localparam logic [CNT_W-1:0] CNT_DATA_1   = 3'd4;
   localparam logic [CNT_W-1:0] CNT_DATA_2   = 3'd5;
   localparam logic [CNT_W-1:0] CNT_DATA_3   = 3'd6;
   localparam logic [CNT_W-1:0] CNT_DONE     = 3'd7;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

endpackage

`default_nettype wire

>>> rtl/bpwm_word_ram.sv
// Simple dual port word store with separate write and read addresses, one write and one registered read per cycle.
// Depends on bpwm_pkg.
`default_nettype none

module bpwm_word_ram #(
   parameter int ADDR_BITS = bpwm_pkg::ADDR_BITS_DEF
) (
   input  wire                              clock,
   input  wire bpwm_pkg::ram_ctl_type       ctl,
   input  wire  [ADDR_BITS-1:0]             wr_addr,
   input  wire  [bpwm_pkg::WORD_W-1:0]      wr_data,
   input  wire  [ADDR_BITS-1:0]             rd_addr,
   output logic [bpwm_pkg::WORD_W-1:0]      rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [bpwm_pkg::WORD_W-1:0] mem_ff [0:DEPTH-1];
   logic [bpwm_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/byte_port_word_memory.sv
// Results: a read data strobe gives its result byte in the cycle after it is taken.
// Throughput: one strobe per cycle, every cycle that busy is low; the word fetch is issued on the
// last address strobe so the RAM read register is ready for the first data strobe.
// Reset: synchronous; busy is high during reset and the cycle after it.
// The word store is not cleared; the receiver cannot stall results.
// Depends on bpwm_pkg and bpwm_word_ram.
`default_nettype none

module byte_port_word_memory #(
   parameter int ADDR_BITS = bpwm_pkg::ADDR_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire                              req_write_mode,
   input  wire                              req_first_strobe,
   input  wire  [bpwm_pkg::BYTE_W-1:0]      req_data_in,
   output logic                             rsp_valid,
   output logic [bpwm_pkg::BYTE_W-1:0]      rsp_data_out,
   output logic                             rsp_last_of_word
);

   logic                              busy_ff;
   logic [bpwm_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                              dir_ff, dir_in;
   logic [bpwm_pkg::WADDR_W-1:0]      waddr_ff, waddr_in;
   logic [23:0]                       gather_ff, gather_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bpwm_pkg::BYTE_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              accept;
   logic [bpwm_pkg::CNT_W-1:0]        pos;
   logic                              dir;
   logic [bpwm_pkg::WORD_W-1:0]       read_word;
   bpwm_pkg::ram_ctl_type             ram_ctl;
   logic [ADDR_BITS-1:0]              rd_addr;
   logic [bpwm_pkg::WADDR_W-1:0]      full_rd_addr;

   assign accept = start && !busy_ff;
   assign pos    = req_first_strobe ? bpwm_pkg::CNT_ADDR_HI : cnt_ff;
   assign dir    = req_first_strobe ? req_write_mode : dir_ff;

   assign full_rd_addr = {waddr_ff[bpwm_pkg::WADDR_W-1:8], req_data_in};
   assign rd_addr      = full_rd_addr[ADDR_BITS-1:0];

   always_comb begin
      cnt_in       = cnt_ff;
      dir_in       = dir_ff;
      waddr_in     = waddr_ff;
      gather_in    = gather_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = 1'b0;
      ram_ctl      = '0;
      if (accept) begin
         dir_in = dir;
         cnt_in = pos;
         if (pos != bpwm_pkg::CNT_DONE) begin
            cnt_in = pos + 3'd1;
            unique case (pos)
               bpwm_pkg::CNT_ADDR_HI: begin
                  waddr_in = {req_data_in[2:0] & bpwm_pkg::HI_ADDR_MASK, 16'h0000};
               end
               bpwm_pkg::CNT_ADDR_MID: begin
                  waddr_in = {waddr_ff[18:16], req_data_in, 8'h00};
               end
               bpwm_pkg::CNT_ADDR_LO: begin
                  waddr_in      = full_rd_addr;
                  ram_ctl.rd_en = !dir;
               end
               default: begin
                  if (dir) begin
                     gather_in     = {gather_ff[15:0], req_data_in};
                     ram_ctl.wr_en = (pos == bpwm_pkg::CNT_DATA_3);
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = (pos == bpwm_pkg::CNT_DATA_3);
                     unique case (pos)
                        bpwm_pkg::CNT_DATA_0: rsp_data_in = read_word[31:24];
                        bpwm_pkg::CNT_DATA_1: rsp_data_in = read_word[23:16];
                        bpwm_pkg::CNT_DATA_2: rsp_data_in = read_word[15:8];
                        default:              rsp_data_in = read_word[7:0];
                     endcase
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         cnt_ff       <= '0;
         dir_ff       <= 1'b0;
         waddr_ff     <= '0;
         gather_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         cnt_ff       <= cnt_in;
         dir_ff       <= dir_in;
         waddr_ff     <= waddr_in;
         gather_ff    <= gather_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   bpwm_word_ram #(
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (waddr_ff[ADDR_BITS-1:0]),
      .wr_data ({gather_ff, req_data_in}),
      .rd_addr (rd_addr),
      .rd_data (read_word)
   );

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_out     = rsp_data_ff;
   assign rsp_last_of_word = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/bpwm_checker.sv
// Port level checks for byte_port_word_memory, attached by bind.
// Depends on bpwm_pkg for the byte width.
`default_nettype none

module bpwm_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           start,
   input wire                           busy,
   input wire                           req_first_strobe,
   input wire                           rsp_valid,
   input wire [bpwm_pkg::BYTE_W-1:0]    rsp_data_out,
   input wire                           rsp_last_of_word
);

   // every result comes from an item taken the cycle before
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without an accepted item");

   // a first strobe is an address byte and never gives a result
   a_no_rsp_on_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(req_first_strobe))
      else $error("result on a first strobe");

   // two last bytes cannot follow each other
   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_word) |=> !(rsp_valid && rsp_last_of_word))
      else $error("back to back last bytes");

   // once out of reset the port takes a strobe every cycle
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("busy outside reset");

   // a result byte and its last flag are never unknown, as a read word must have been written
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_data_out, rsp_last_of_word}))
      else $error("unknown result byte");

endmodule

bind byte_port_word_memory bpwm_checker u_bpwm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_first_strobe (req_first_strobe),
   .rsp_valid        (rsp_valid),
   .rsp_data_out     (rsp_data_out),
   .rsp_last_of_word (rsp_last_of_word)
);

`default_nettype wire

>>> dv/byte_port_word_memory_checker.sv
// Checker for byte_port_word_memory: tracks host strobe accesses, predicts the
// returned read bytes and compares them with the result strobes.
// Depends on bpwm_pkg.

module byte_port_word_memory_checker #(
   parameter int ADDR_BITS = bpwm_pkg::ADDR_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire                          busy,
   input  wire                          req_write_mode,
   input  wire                          req_first_strobe,
   input  wire  [bpwm_pkg::BYTE_W-1:0]  req_data_in,
   input  wire                          rsp_valid,
   input  wire  [bpwm_pkg::BYTE_W-1:0]  rsp_data_out,
   input  wire                          rsp_last_of_word,
   output int                           errors,
   output int                           pending
);

   logic [bpwm_pkg::CNT_W-1:0]   strobe_pos;
   logic                         access_write;
   logic [bpwm_pkg::WADDR_W-1:0] word_addr;
   logic [23:0]                  gathered;
   logic [bpwm_pkg::WORD_W-1:0]  fetched_word;
   logic [bpwm_pkg::WORD_W-1:0]  words [0:(1<<ADDR_BITS)-1];
   logic [bpwm_pkg::BYTE_W:0]    expected_bytes [$];   // {last_of_word, data_out}

   initial begin
      errors = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string what, input logic [bpwm_pkg::BYTE_W:0] got,
                                  input logic [bpwm_pkg::BYTE_W:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   task automatic take_strobe(input logic wm, input logic fs,
                              input logic [bpwm_pkg::BYTE_W-1:0] d);
      logic [bpwm_pkg::CNT_W-1:0]  pos;
      logic [bpwm_pkg::WORD_W-1:0] shifted;
      if (fs) begin
         strobe_pos = bpwm_pkg::CNT_ADDR_HI;
         access_write = wm;
      end
      pos = strobe_pos;
      if (pos != bpwm_pkg::CNT_DONE) begin
         strobe_pos = pos + 1'b1;
         case (pos)
            bpwm_pkg::CNT_ADDR_HI: begin
               word_addr = {d[2:0] & bpwm_pkg::HI_ADDR_MASK, 16'h0000};
            end
            bpwm_pkg::CNT_ADDR_MID: begin
               word_addr = {word_addr[18:16], d, 8'h00};
            end
            bpwm_pkg::CNT_ADDR_LO: begin
               word_addr[7:0] = d;
               if (!access_write)
                  fetched_word = words[word_addr[ADDR_BITS-1:0]];
            end
            default: begin
               if (access_write && pos == bpwm_pkg::CNT_DATA_3)
                  words[word_addr[ADDR_BITS-1:0]] = {gathered, d};
               else if (access_write)
                  gathered = {gathered[15:0], d};
               else begin
                  // most significant byte first
                  shifted = fetched_word >> (bpwm_pkg::BYTE_W * (bpwm_pkg::CNT_DATA_3 - pos));
                  expected_bytes.push_back({pos == bpwm_pkg::CNT_DATA_3,
                                            shifted[bpwm_pkg::BYTE_W-1:0]});
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      logic [bpwm_pkg::BYTE_W:0] want;
      if (reset) begin
         strobe_pos = bpwm_pkg::CNT_ADDR_HI;
         access_write = 1'b0;
         word_addr = '0;
         gathered = '0;
         fetched_word = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("result with none expected",
                               {rsp_last_of_word, rsp_data_out}, '0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data_out !== want[bpwm_pkg::BYTE_W-1:0])
                  report_mismatch("data_out", {1'b0, rsp_data_out},
                                  {1'b0, want[bpwm_pkg::BYTE_W-1:0]});
               if (rsp_last_of_word !== want[bpwm_pkg::BYTE_W])
                  report_mismatch("last_of_word", {8'h00, rsp_last_of_word},
                                  {8'h00, want[bpwm_pkg::BYTE_W]});
            end
         end
         if (start && !busy)
            take_strobe(req_write_mode, req_first_strobe, req_data_in);
      end
      pending = expected_bytes.size();
   end

endmodule

>>> dv/byte_port_word_memory_tb.sv
// Testbench top for byte_port_word_memory: drives host strobe accesses with
// random sender gaps and gives the verdict. Depends on bpwm_pkg, the RTL and
// byte_port_word_memory_checker.

module byte_port_word_memory_tb;

   localparam int AB             = bpwm_pkg::ADDR_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 560;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        req_write_mode = 1'b0;
   logic                        req_first_strobe = 1'b0;
   logic [bpwm_pkg::BYTE_W-1:0] req_data_in = '0;
   wire                         busy;
   wire                         rsp_valid;
   wire  [bpwm_pkg::BYTE_W-1:0] rsp_data_out;
   wire                         rsp_last_of_word;

   int errors;
   int pending;
   int stall_cycles = 0;
   int useful_items = 0;
   int sender_idle_pct = 0;
   int idle_plan [3] = '{0, 50, 13};

   bit                           written_map [0:(1<<AB)-1];
   int                           written_list [$];
   logic [bpwm_pkg::WADDR_W-1:0] last_written = '0;

   byte_port_word_memory #(.ADDR_BITS(AB)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_write_mode   (req_write_mode),
      .req_first_strobe (req_first_strobe),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_of_word (rsp_last_of_word)
   );

   byte_port_word_memory_checker #(.ADDR_BITS(AB)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_write_mode   (req_write_mode),
      .req_first_strobe (req_first_strobe),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_of_word (rsp_last_of_word),
      .errors           (errors),
      .pending          (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("byte_port_word_memory_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_strobe(input logic wm, input logic fs,
                              input logic [bpwm_pkg::BYTE_W-1:0] d);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_write_mode <= wm;
      req_first_strobe <= fs;
      req_data_in <= d;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // n strobes of one access; direction on later strobes is random and must be ignored
   task automatic send_access(input logic dir, input logic [4:0] pad,
                              input logic [bpwm_pkg::WADDR_W-1:0] addr,
                              input logic [bpwm_pkg::WORD_W-1:0] word,
                              input int n, input int extras);
      logic [bpwm_pkg::BYTE_W-1:0] b [0:6];
      int i;
      b[0] = {pad, addr[18:16]};
      b[1] = addr[15:8];
      b[2] = addr[7:0];
      b[3] = word[31:24];
      b[4] = word[23:16];
      b[5] = word[15:8];
      b[6] = word[7:0];
      for (i = 0; i < n; i++)
         send_strobe((i == 0) ? dir : 1'($urandom_range(1)), i == 0, b[i]);
      for (i = 0; i < extras; i++)
         send_strobe(1'($urandom_range(1)), 1'b0, 8'($urandom));
      useful_items += n;
      if (dir && n == 7) begin
         if (!written_map[addr[AB-1:0]]) begin
            written_map[addr[AB-1:0]] = 1'b1;
            written_list.push_back(int'(addr[AB-1:0]));
         end
         last_written = addr;
      end
   endtask

   // an address whose store entry was written, with random bits above the depth
   function automatic logic [bpwm_pkg::WADDR_W-1:0] read_target();
      logic [bpwm_pkg::WADDR_W-1:0] a;
      a = bpwm_pkg::WADDR_W'($urandom);
      if ($urandom_range(1) == 1)
         a[AB-1:0] = last_written[AB-1:0];
      else
         a[AB-1:0] = AB'(written_list[$urandom_range(written_list.size() - 1)]);
      return a;
   endfunction

   function automatic logic [bpwm_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return bpwm_pkg::WORD_W'($urandom);
      endcase
   endfunction

   task automatic random_access();
      int kind;
      int n;
      int extras;
      kind = $urandom_range(99);
      extras = ($urandom_range(3) == 0) ? int'($urandom_range(1, 3)) : 0;
      if (kind < 40) begin
         send_access(1'b1, 5'($urandom), bpwm_pkg::WADDR_W'($urandom), pick_word(), 7,
                     extras);
      end else if (kind < 80) begin
         send_access(1'b0, 5'($urandom), read_target(), bpwm_pkg::WORD_W'($urandom), 7,
                     extras);
      end else if (kind < 90) begin
         // abandoned write: never stores
         send_access(1'b1, 5'($urandom), bpwm_pkg::WADDR_W'($urandom), pick_word(),
                     $urandom_range(1, 6), 0);
      end else begin
         // abandoned read: once the address is complete the word is fetched
         n = $urandom_range(1, 6);
         send_access(1'b0, 5'($urandom),
                     (n >= 3) ? read_target() : bpwm_pkg::WADDR_W'($urandom),
                     bpwm_pkg::WORD_W'($urandom), n, 0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no first strobe after reset: counts as a read, stopped before the fetch
      send_strobe(1'b1, 1'b0, 8'h00);
      send_strobe(1'b0, 1'b0, 8'hA5);
      // top address, masked high byte, all ones
      send_access(1'b1, 5'h1F, 19'h7FFFF, 32'hFFFF_FFFF, 7, 0);
      // read back the top address through its alias within the depth, then strobes past the end of the access
      send_access(1'b0, 5'h00, 19'h01FFF, 32'h0, 7, 2);
      send_access(1'b1, 5'h00, 19'h00000, 32'h0, 7, 0);

      foreach (idle_plan[p]) begin
         sender_idle_pct = idle_plan[p];
         useful_items = 0;
         while (useful_items < PHASE_ITEMS)
            random_access();
         // drain before the next phase
         start <= 1'b0;
         @(negedge clock);
         while (pending != 0)
            @(negedge clock);
      end

      repeat (8) @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("byte_port_word_memory_tb OK");
      else
         $display("byte_port_word_memory_tb NOT OK");
      $finish;
   end

endmodule
